// ===== rtl/fce_pkg.sv =====
`default_nettype none

package fce_pkg;

    localparam int INPUTS_MAX  = 4;
    localparam int OUTPUTS_MAX = 8;
    localparam int MEMORY_MAX  = 7;

    localparam int DATA_W    = INPUTS_MAX;
    localparam int CODE_W    = OUTPUTS_MAX;
    localparam int GEN_W     = 8;
    localparam int WIN_W     = MEMORY_MAX + 1;
    localparam int MEM_W     = $clog2(MEMORY_MAX + 1);
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int K_W       = 3;
    localparam int N_W       = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INPUTS_USED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUTS_USED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GEN_ROW0     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GEN_ROW1     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GEN_ROW2     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GEN_ROW3     = 3'd5;

    typedef struct packed {
        logic [DATA_W-1:0] data_bits;
        logic              block_end;
    } t_in_item;

    typedef struct packed {
        logic [CODE_W-1:0] code_bits;
        logic              last_out;
    } t_out_item;

    // one queued job between front and back
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              block_end;
    } t_job;

    typedef logic [INPUTS_MAX-1:0][MEMORY_MAX-1:0] t_sr_arr;

    // encoder setup derived from the configuration registers
    typedef struct packed {
        logic [INPUTS_MAX-1:0][OUTPUTS_MAX-1:0][WIN_W-1:0] taps;
        logic [INPUTS_MAX-1:0][MEMORY_MAX-1:0]             keep_mask;
        logic [INPUTS_MAX-1:0]                             active;
        logic [MEM_W-1:0]                                  tail_len;
    } t_enc_cfg;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        t_sr_arr           sr;
    } t_enc_res;

    // one encoder step: window bit d is the input bit from d groups back
    function automatic t_enc_res encode_group(t_enc_cfg c, t_sr_arr sr,
                                              logic [DATA_W-1:0] bits);
        t_enc_res         r;
        logic [WIN_W-1:0] win;
        r.code = '0;
        r.sr   = sr;
        for (int i = 0; i < INPUTS_MAX; i++) begin
            win = {sr[i], bits[i]};
            for (int j = 0; j < OUTPUTS_MAX; j++) begin
                r.code[j] = r.code[j] ^ (^(c.taps[i][j] & win));
            end
            if (c.active[i]) begin
                r.sr[i] = win[MEMORY_MAX-1:0] & c.keep_mask[i];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fce_cfg.sv =====
`default_nettype none

module fce_cfg
    import fce_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_W-1:0]      i_cfg_data,
    output logic      [INPUTS_MAX-1:0] o_active,
    output t_enc_cfg                   o_enc
);

    logic [K_W-1:0]                   r_inputs_used;
    logic [N_W-1:0]                   r_outputs_used;
    logic [INPUTS_MAX-1:0][CFG_W-1:0] r_gen;
    t_enc_cfg                         r_enc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inputs_used  <= K_W'(1);
            r_outputs_used <= N_W'(2);
            r_gen          <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INPUTS_USED:  r_inputs_used  <= i_cfg_data[K_W-1:0];
                CFG_OUTPUTS_USED: r_outputs_used <= i_cfg_data[N_W-1:0];
                CFG_GEN_ROW0:     r_gen[0]       <= i_cfg_data;
                CFG_GEN_ROW1:     r_gen[1]       <= i_cfg_data;
                CFG_GEN_ROW2:     r_gen[2]       <= i_cfg_data;
                CFG_GEN_ROW3:     r_gen[3]       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    function automatic int eff_k(logic [K_W-1:0] k);
        int r;
        r = int'(k);
        if (r == 0) r = 1;
        if (r > INPUTS_MAX) r = INPUTS_MAX;
        return r;
    endfunction

    function automatic int eff_n(logic [N_W-1:0] n);
        int r;
        r = int'(n);
        if (r == 0) r = 1;
        if (r > OUTPUTS_MAX) r = OUTPUTS_MAX;
        return r;
    endfunction

    function automatic t_enc_cfg derive(logic [K_W-1:0] k_raw, logic [N_W-1:0] n_raw,
                                        logic [INPUTS_MAX-1:0][CFG_W-1:0] gens);
        t_enc_cfg         c;
        int               k;
        int               n;
        logic [MEM_W-1:0] mem;
        logic [MEM_W-1:0] deg;
        logic [GEN_W-1:0] g;
        k = eff_k(k_raw);
        n = eff_n(n_raw);
        c = '0;
        for (int i = 0; i < INPUTS_MAX; i++) begin
            mem = '0;
            // memory length of this input: highest tap degree over used outputs
            for (int j = 0; j < OUTPUTS_MAX; j++) begin
                g   = gens[i][j*GEN_W +: GEN_W];
                deg = '0;
                for (int b = 0; b < GEN_W; b++) begin
                    if (g[b]) deg = (b > MEMORY_MAX) ? MEM_W'(MEMORY_MAX) : MEM_W'(b);
                end
                if (j < n && deg > mem) mem = deg;
            end
            if (i < k) begin
                c.active[i] = 1'b1;
                // reverse generator so tap d meets the bit from d groups back
                for (int j = 0; j < n; j++) begin
                    g = gens[i][j*GEN_W +: GEN_W];
                    for (int d = 0; d < WIN_W; d++) begin
                        if (d <= int'(mem)) c.taps[i][j][d] = g[int'(mem) - d];
                    end
                end
                for (int b = 0; b < MEMORY_MAX; b++) begin
                    c.keep_mask[i][b] = (b < int'(mem));
                end
                if (mem > c.tail_len) c.tail_len = mem;
            end
        end
        return c;
    endfunction

    always_ff @(posedge i_clk) begin
        r_enc <= derive(r_inputs_used, r_outputs_used, r_gen);
    end

    always_comb begin
        for (int i = 0; i < INPUTS_MAX; i++) begin
            o_active[i] = (i < eff_k(r_inputs_used));
        end
    end

    assign o_enc = r_enc;

endmodule

`default_nettype wire

// ===== rtl/fce_front.sv =====
`default_nettype none

module fce_front
    import fce_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire t_in_item              i_in,
    input  wire logic [INPUTS_MAX-1:0] i_active,
    output logic                       o_job_valid,
    output t_job                       o_job,
    input  wire logic                  i_job_pop
);

    localparam int QDEPTH = 2;

    t_job             r_q [QDEPTH];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;
    logic             push;
    t_job             job_in;

    assign o_ready = (r_cnt != 2'(QDEPTH));
    assign push    = i_valid && o_ready;

    // drop data bits of inputs that are not in use
    always_comb begin
        job_in.data      = i_in.data_bits & i_active;
        job_in.block_end = i_in.block_end;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_job_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_job_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push)      r_wptr <= ~r_wptr;
            if (i_job_pop) r_rptr <= ~r_rptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wptr] <= job_in;
    end

    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rptr];

endmodule

`default_nettype wire

// ===== rtl/fce_back.sv =====
`default_nettype none

module fce_back
    import fce_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_enc_cfg  i_enc,
    input  wire logic      i_job_valid,
    input  wire t_job      i_job,
    output logic           o_job_pop,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_item
);

    t_sr_arr          r_sr;
    logic [MEM_W-1:0] r_tail_cnt;
    logic             r_valid;
    t_out_item        r_item;

    logic             advance;
    logic             flushing;
    logic             step;
    logic             blk_done;
    logic [DATA_W-1:0] bits;
    t_enc_res         res;

    assign advance   = !r_valid || i_ready;
    assign flushing  = (r_tail_cnt != '0);
    assign step      = advance && (flushing || i_job_valid);
    assign o_job_pop = advance && !flushing && i_job_valid;

    // block finishes on the last tail group, or on the end group itself with no tail
    assign blk_done = flushing ? (r_tail_cnt == MEM_W'(1))
                               : (i_job.block_end && (i_enc.tail_len == '0));

    assign bits = flushing ? '0 : i_job.data;
    assign res  = encode_group(i_enc, r_sr, bits);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr       <= '0;
            r_tail_cnt <= '0;
            r_valid    <= 1'b0;
        end else begin
            if (advance) r_valid <= step;
            if (step) begin
                r_sr <= blk_done ? '0 : res.sr;
                if (flushing) begin
                    r_tail_cnt <= r_tail_cnt - MEM_W'(1);
                end else if (i_job.block_end) begin
                    r_tail_cnt <= i_enc.tail_len;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_item.code_bits <= res.code;
            r_item.last_out  <= blk_done;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== rtl/feedforward_convolutional_encoder.sv =====
// feedforward convolutional encoder, rate k/n, zero-tail terminated
// input channel: i_valid / o_ready carry one item i_in = {data_bits, block_end},
//   bit i of data_bits feeds input i; bits of unused inputs are ignored
// output channel: o_valid / i_ready carry one item o_out = {code_bits, last_out}
// config port: i_cfg_we, i_cfg_idx, i_cfg_data; write only while no item is in flight
//   0 inputs_used, 1 outputs_used, 2..5 gen_row0..3 (byte j = generator to output j)
// latency: an item accepted at one edge can be taken at the second edge after it
// throughput: one item per cycle, set by the single encoder step in the back end;
//   an item with block_end also emits m zero-tail groups (m = largest memory),
//   one per cycle, during which the back end pops nothing; last group has last_out
// a two-entry queue sits between the accepting front and the encoding back end,
//   so input keeps flowing while a result waits in the output register
// receiver stall: the output register holds, the queue fills, then o_ready drops
// reset: shift registers cleared, queue and output emptied, k=1, n=2, generators 0
`default_nettype none

module feedforward_convolutional_encoder
    import fce_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire t_in_item             i_in,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output t_out_item                 o_out
);

    logic [INPUTS_MAX-1:0] active;   // live input mask for the front end
    t_enc_cfg              enc;      // registered encoder setup for the back end
    logic                  job_valid;
    t_job                  job;
    logic                  job_pop;

    // configuration registers and derived tap tables
    fce_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_active   (active),
        .o_enc      (enc)
    );

    // accept and queue items
    fce_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in        (i_in),
        .i_active    (active),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    // encode, run the zero tail, drive the output register
    fce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enc       (enc),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_out)
    );

endmodule

`default_nettype wire
